>>> src/fmbq_pkg.sv
// fmbq_pkg: request codes, default sizes and the control word shared by the
// front/middle/back queue top level and its entry store. No dependencies.
`default_nettype none

package fmbq_pkg;

    // Fixed field widths of the request and result words
    localparam int REQ_W   = 3;
    localparam int VALUE_W = 32;

    // Default sizes
    localparam int DEPTH_DEF      = 16;
    localparam int WORD_WIDTH_DEF = 32;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_MIDDLE = 3'd1;
    localparam logic [REQ_W-1:0] REQ_PUSH_BACK   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_POP_FRONT   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_POP_MIDDLE  = 3'd4;
    localparam logic [REQ_W-1:0] REQ_POP_BACK    = 3'd5;

    // Where in the sequence a request acts
    typedef enum logic [2:0] {
        SIDE_FRONT  = 3'b001,
        SIDE_MIDDLE = 3'b010,
        SIDE_BACK   = 3'b100
    } t_side;

    // One store update; push and pop are never both set
    typedef struct packed {
        logic  push;
        logic  pop;
        t_side side;
    } t_store_op;

endpackage

`default_nettype wire

>>> src/fmbq_store.sv
// fmbq_store: register array and entry count of the queue, with the one-place
// shift that a push or pop needs. Depends on fmbq_pkg.
`default_nettype none

module fmbq_store #(
    parameter int DEPTH      = fmbq_pkg::DEPTH_DEF,
    parameter int WORD_WIDTH = fmbq_pkg::WORD_WIDTH_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire fmbq_pkg::t_store_op            i_op,
    input  wire logic [WORD_WIDTH-1:0]          i_word,
    output logic      [WORD_WIDTH-1:0]          o_rd_word,
    output logic      [$clog2(DEPTH+1)-1:0]     o_count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WORD_WIDTH-1:0] r_entries [DEPTH];
    logic [WORD_WIDTH-1:0] n_entries [DEPTH];
    logic [WORD_WIDTH-1:0] w_left    [DEPTH];
    logic [WORD_WIDTH-1:0] w_right   [DEPTH];
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;
    logic [CW-1:0]         w_cnt_m1;
    logic [CW-1:0]         w_pos_wide;
    logic [AW-1:0]         w_pos;

    assign w_cnt_m1 = r_count - CW'(1);

    // Position of the insert or removal
    always_comb begin
        w_pos_wide = '0;
        case (i_op.side)
            fmbq_pkg::SIDE_FRONT:  w_pos_wide = '0;
            fmbq_pkg::SIDE_MIDDLE: w_pos_wide = i_op.pop ? (w_cnt_m1 >> 1) : (r_count >> 1);
            fmbq_pkg::SIDE_BACK:   w_pos_wide = i_op.pop ? w_cnt_m1 : r_count;
            default:               w_pos_wide = '0;
        endcase
    end

    assign w_pos     = w_pos_wide[AW-1:0];
    assign o_rd_word = r_entries[w_pos];
    assign o_count   = r_count;

    for (genvar g = 0; g < DEPTH; g++) begin : g_entry
        if (g == 0) begin : g_first
            assign w_left[g] = i_word;
        end else begin : g_inner_l
            assign w_left[g] = r_entries[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign w_right[g] = r_entries[g];
        end else begin : g_inner_r
            assign w_right[g] = r_entries[g+1];
        end

        always_comb begin
            n_entries[g] = r_entries[g];
            if (i_op.push) begin
                if (AW'(g) == w_pos) begin
                    n_entries[g] = i_word;
                end else if (AW'(g) > w_pos) begin
                    n_entries[g] = w_left[g];
                end
            end else if (i_op.pop) begin
                if (AW'(g) >= w_pos) begin
                    n_entries[g] = w_right[g];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            r_entries[g] <= n_entries[g];
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_op.push) begin
            n_count = r_count + CW'(1);
        end else if (i_op.pop) begin
            n_count = w_cnt_m1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

>>> src/front_middle_back_queue_core.sv
// front_middle_back_queue_core: top level of the front/middle/back queue.
// Depends on fmbq_pkg and fmbq_store.
`default_nettype none

// The queue holds up to DEPTH signed words in order and takes one request
// per word on the input channel: push or pop at the front, the middle or the
// back. A middle push with n words held inserts at position n/2 (rounded
// down), a middle pop removes position (n-1)/2. Every request gives exactly
// one result word: the popped value sign-extended to 32 bits (zero for
// pushes), an empty flag for a pop on an empty queue, a full flag for a push
// dropped on a full queue, and the occupancy after the request. Request codes
// 6 and 7 change nothing and report no error. The block sustains one request
// per clock while the result channel is not stalled; a request goes from the
// input register through the entry array update into the result register,
// which it enters when that register is free or being drained. The limit is
// the single shift of the register array per cycle. Both channels use
// valid/stall; the input register and the result register let a new request
// enter while a finished result still waits.
module front_middle_back_queue_core #(
    parameter int DEPTH      = fmbq_pkg::DEPTH_DEF,
    parameter int WORD_WIDTH = fmbq_pkg::WORD_WIDTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // request channel
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic [fmbq_pkg::REQ_W-1:0]        i_req_type,
    input  wire logic signed [fmbq_pkg::VALUE_W-1:0] i_push_value,
    // result channel
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic signed [fmbq_pkg::VALUE_W-1:0]    o_pop_value,
    output logic                                   o_empty_error,
    output logic                                   o_full_error,
    output logic      [$clog2(DEPTH+1)-1:0]        o_occupancy
);

    localparam int CW = $clog2(DEPTH + 1);
    // sign-extension width: at least as wide as the result field
    localparam int XW = (WORD_WIDTH > fmbq_pkg::VALUE_W) ? WORD_WIDTH : fmbq_pkg::VALUE_W;

    // input register
    logic                              r_in_valid;
    logic [fmbq_pkg::REQ_W-1:0]        r_req;
    logic [fmbq_pkg::VALUE_W-1:0]      r_push;

    // result register
    logic                              r_out_valid;
    logic [fmbq_pkg::VALUE_W-1:0]      r_pop_value;
    logic                              r_empty_error;
    logic                              r_full_error;
    logic [CW-1:0]                     r_occupancy;

    logic                  w_fire;
    logic                  w_is_push;
    logic                  w_is_pop;
    fmbq_pkg::t_side       w_side;
    logic                  w_full;
    logic                  w_empty;
    fmbq_pkg::t_store_op   w_op;
    logic [WORD_WIDTH-1:0] w_word;
    logic [WORD_WIDTH-1:0] w_rd_word;
    logic [XW-1:0]         w_rd_ext;
    logic [CW-1:0]         w_count;
    logic [CW-1:0]         n_occupancy;

    // Advance the request into the result register when that register is
    // free or being drained this cycle.
    assign w_fire     = r_in_valid && (!r_out_valid || !i_out_stall);
    // Hold the input register while its request cannot advance.
    assign o_in_stall = r_in_valid && !w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_req  <= i_req_type;
            r_push <= $unsigned(i_push_value);
        end
    end

    // Decode the request code.
    always_comb begin
        w_is_push = 1'b0;
        w_is_pop  = 1'b0;
        w_side    = fmbq_pkg::SIDE_FRONT;
        case (r_req)
            fmbq_pkg::REQ_PUSH_FRONT: begin
                w_is_push = 1'b1;
                w_side    = fmbq_pkg::SIDE_FRONT;
            end
            fmbq_pkg::REQ_PUSH_MIDDLE: begin
                w_is_push = 1'b1;
                w_side    = fmbq_pkg::SIDE_MIDDLE;
            end
            fmbq_pkg::REQ_PUSH_BACK: begin
                w_is_push = 1'b1;
                w_side    = fmbq_pkg::SIDE_BACK;
            end
            fmbq_pkg::REQ_POP_FRONT: begin
                w_is_pop = 1'b1;
                w_side   = fmbq_pkg::SIDE_FRONT;
            end
            fmbq_pkg::REQ_POP_MIDDLE: begin
                w_is_pop = 1'b1;
                w_side   = fmbq_pkg::SIDE_MIDDLE;
            end
            fmbq_pkg::REQ_POP_BACK: begin
                w_is_pop = 1'b1;
                w_side   = fmbq_pkg::SIDE_BACK;
            end
            default: begin
                // unused codes: leave the queue alone
                w_is_push = 1'b0;
                w_is_pop  = 1'b0;
            end
        endcase
    end

    assign w_full  = (w_count == CW'(DEPTH));
    assign w_empty = (w_count == '0);

    // Drop pushes on a full queue and pops on an empty one.
    assign w_op.push = w_fire && w_is_push && !w_full;
    assign w_op.pop  = w_fire && w_is_pop && !w_empty;
    assign w_op.side = w_side;

    // Store the low WORD_WIDTH bits of the word, zero-filled above 32 bits.
    assign w_word = WORD_WIDTH'(r_push);

    fmbq_store #(
        .DEPTH      (DEPTH),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_op      (w_op),
        .i_word    (w_word),
        .o_rd_word (w_rd_word),
        .o_count   (w_count)
    );

    // Sign-extend the popped word from WORD_WIDTH bits.
    assign w_rd_ext = XW'(signed'(w_rd_word));

    always_comb begin
        n_occupancy = w_count;
        if (w_op.push) begin
            n_occupancy = w_count + CW'(1);
        end else if (w_op.pop) begin
            n_occupancy = w_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_pop_value   <= w_op.pop ? w_rd_ext[fmbq_pkg::VALUE_W-1:0] : '0;
            r_empty_error <= w_is_pop && w_empty;
            r_full_error  <= w_is_push && w_full;
            r_occupancy   <= n_occupancy;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pop_value   = signed'(r_pop_value);
    assign o_empty_error = r_empty_error;
    assign o_full_error  = r_full_error;
    assign o_occupancy   = r_occupancy;

endmodule

`default_nettype wire

>>> src/fmbq_check.sv
// fmbq_check: port-level assertions for the front/middle/back queue, bound to
// front_middle_back_queue_core. Depends on fmbq_pkg.
`default_nettype none

module fmbq_check #(
    parameter int DEPTH = fmbq_pkg::DEPTH_DEF,
    parameter int OCC_W = $clog2(fmbq_pkg::DEPTH_DEF + 1)
) (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               o_out_valid,
    input wire logic                               i_out_stall,
    input wire logic signed [fmbq_pkg::VALUE_W-1:0] o_pop_value,
    input wire logic                               o_empty_error,
    input wire logic                               o_full_error,
    input wire logic [OCC_W-1:0]                   o_occupancy
);

    // occupancy never exceeds the capacity
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_occupancy <= OCC_W'(DEPTH)))
        else $error("occupancy above capacity");

    // an empty pop leaves nothing held and returns zero
    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_empty_error) |-> (o_occupancy == '0 && o_pop_value == '0
                                            && !o_full_error))
        else $error("empty error with inconsistent result");

    // a dropped push leaves the queue full and pops nothing
    a_full_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_full_error) |-> (o_occupancy == OCC_W'(DEPTH)
                                           && o_pop_value == '0))
        else $error("full error with inconsistent result");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_pop_value)
                                          && $stable(o_occupancy)))
        else $error("stalled result changed");

endmodule

bind front_middle_back_queue_core fmbq_check #(
    .DEPTH (DEPTH),
    .OCC_W ($clog2(DEPTH + 1))
) u_fmbq_check (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_pop_value   (o_pop_value),
    .o_empty_error (o_empty_error),
    .o_full_error  (o_full_error),
    .o_occupancy   (o_occupancy)
);

`default_nettype wire
